@@ hdl/mrp_pkg.sv @@
`default_nettype none
package mrp_pkg;

  localparam int unsigned TableLen = 12;
  localparam int unsigned MaxBits = 63;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SPLIT,
    ST_BASE,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_POW_NEXT,
    ST_EVAL,
    ST_SQR,
    ST_SQR_EVAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } mul_ctl_t;

  function automatic logic [5:0] base_value(input logic [3:0] idx);
    logic [5:0] v;
    unique case (idx)
      4'd0: v = 6'd2;
      4'd1: v = 6'd3;
      4'd2: v = 6'd5;
      4'd3: v = 6'd7;
      4'd4: v = 6'd11;
      4'd5: v = 6'd13;
      4'd6: v = 6'd17;
      4'd7: v = 6'd19;
      4'd8: v = 6'd23;
      4'd9: v = 6'd29;
      4'd10: v = 6'd31;
      4'd11: v = 6'd37;
      default: v = 6'd37;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hdl/mrp_mulmod.sv @@
`default_nettype none
// double-and-add modular multiply, one bit of y per cycle
module mrp_mulmod import mrp_pkg::*; #(
  parameter int unsigned W = 63
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] x_i,
  input  wire logic [W-1:0] y_i,
  input  wire logic [W-1:0] m_i,
  output mul_ctl_t          ctl_o,
  output logic [W-1:0]      r_o
);

  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    r_q, r_d, x_q, y_q, y_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [W:0]      dbl, dbl_s, sum, sum_s;
  logic [W-1:0]    dbl_r;

  always_comb begin
    dbl   = {r_q, 1'b0};
    dbl_s = dbl - {1'b0, m_i};
    dbl_r = (dbl >= {1'b0, m_i}) ? dbl_s[W-1:0] : dbl[W-1:0];
    sum   = {1'b0, dbl_r} + {1'b0, x_q};
    sum_s = sum - {1'b0, m_i};
  end

  always_comb begin
    r_d    = r_q;
    y_d    = y_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      r_d    = '0;
      y_d    = y_i;
      cnt_d  = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (y_q[W-1]) begin
        r_d = (sum >= {1'b0, m_i}) ? sum_s[W-1:0] : sum[W-1:0];
      end else begin
        r_d = dbl_r;
      end
      y_d   = {y_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    y_q <= y_d;
    if (start_i) begin
      x_q <= x_i;
    end
  end

  assign ctl_o = '{start: start_i, busy: busy_q, done: done_q};
  assign r_o   = r_q;

endmodule
`default_nettype wire

@@ hdl/miller_rabin_primality_64_top.sv @@
// channel | valid       | stall       | payload
// input   | in_valid_i  | in_stall_o  | candidate_i
// output  | out_valid_o | out_stall_i | prime_flag_o
// one item at a time; in_stall_o is high from acceptance until the result is taken
// each modular multiply runs in one shared shift-add unit
// rst_ni clears the sequencer and the output valid
// a held result stalls only the next acceptance
`default_nettype none
module miller_rabin_primality_64_top import mrp_pkg::*; #(
  parameter int unsigned VALUE_BITS = 63,
  parameter int unsigned BASE_COUNT = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [VALUE_BITS-1:0] candidate_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       prime_flag_o
);

  localparam int unsigned W = VALUE_BITS;
  localparam int unsigned SW = $clog2(W + 1);
  localparam logic [3:0] LastBase = 4'(BASE_COUNT - 1);

  state_e state_q, state_d;
  logic [W-1:0]  n_q, d_q, d_d, e_q, e_d, acc_q, acc_d, b_q, b_d;
  logic [SW-1:0] s_q, s_d, r_q, r_d;
  logic [3:0]    bi_q, bi_d;
  logic          res_q, res_d, ov_q, ov_d;
  logic          mul_start;
  logic [W-1:0]  mul_x, mul_y, mul_r, nm1, base_w;
  mul_ctl_t      mul_ctl;

  assign nm1    = n_q - 1'b1;
  assign base_w = W'(base_value(bi_q));

  mrp_mulmod #(.W(W)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .m_i    (n_q),
    .ctl_o  (mul_ctl),
    .r_o    (mul_r)
  );

  logic accept_in;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || ov_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (accept_in) state_d = ST_CHECK;
      ST_CHECK: begin
        if (n_q < W'(4) || !n_q[0]) state_d = ST_DONE;
        else state_d = ST_SPLIT;
      end
      ST_SPLIT:    if (d_q[0]) state_d = ST_BASE;
      ST_BASE: begin
        if (base_w >= n_q) state_d = ST_DONE;
        else if (e_q == '0) state_d = ST_EVAL;
        else if (e_q[0]) state_d = ST_POW_MUL;
        else state_d = ST_POW_SQR;
      end
      ST_POW_MUL:  if (mul_ctl.done) state_d = ST_POW_SQR;
      ST_POW_SQR:  if (mul_ctl.done) state_d = ST_POW_NEXT;
      ST_POW_NEXT: begin
        if (e_q == '0) state_d = ST_EVAL;
        else if (e_q[0]) state_d = ST_POW_MUL;
        else state_d = ST_POW_SQR;
      end
      ST_EVAL: begin
        if (acc_q == W'(1) || acc_q == nm1 || r_q >= s_q) begin
          if (acc_q != W'(1) && acc_q != nm1) state_d = ST_DONE;
          else if (bi_q == LastBase) state_d = ST_DONE;
          else state_d = ST_BASE;
        end else state_d = ST_SQR;
      end
      ST_SQR:      if (mul_ctl.done) state_d = ST_SQR_EVAL;
      ST_SQR_EVAL: begin
        if (acc_q == nm1) begin
          if (bi_q == LastBase) state_d = ST_DONE;
          else state_d = ST_BASE;
        end else if (r_q >= s_q) state_d = ST_DONE;
        else state_d = ST_SQR;
      end
      ST_DONE:     state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    d_d = d_q; e_d = e_q; acc_d = acc_q; b_d = b_q;
    s_d = s_q; r_d = r_q; bi_d = bi_q; res_d = res_q; ov_d = ov_q;
    mul_start = 1'b0;
    mul_x = acc_q;
    mul_y = b_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        bi_d = '0;
        s_d  = '0;
      end
      ST_CHECK: begin
        res_d = (n_q == W'(2)) || (n_q == W'(3));
        d_d   = nm1;
      end
      ST_SPLIT: begin
        if (!d_q[0]) begin
          d_d = d_q >> 1;
          s_d = s_q + 1'b1;
        end else begin
          e_d = d_q;
        end
      end
      ST_BASE: begin
        res_d = 1'b1;
        acc_d = W'(1);
        b_d   = base_w;
        r_d   = SW'(1);
        if (base_w < n_q && e_q != '0) begin
          mul_start = 1'b1;
          if (!e_q[0]) begin
            mul_x = base_w;
            mul_y = base_w;
          end else begin
            mul_x = W'(1);
            mul_y = base_w;
          end
        end
      end
      ST_POW_MUL: if (mul_ctl.done) begin
        acc_d = mul_r;
        mul_start = 1'b1;
        mul_x = b_q;
        mul_y = b_q;
      end
      ST_POW_SQR: if (mul_ctl.done) begin
        b_d = mul_r;
        e_d = e_q >> 1;
      end
      ST_POW_NEXT: begin
        if (e_q != '0) begin
          mul_start = 1'b1;
          mul_x = e_q[0] ? acc_q : b_q;
          mul_y = b_q;
        end
      end
      ST_EVAL: begin
        if (acc_q == W'(1) || acc_q == nm1) begin
          bi_d = bi_q + 1'b1;
          e_d  = d_q;
        end else if (r_q >= s_q) begin
          res_d = 1'b0;
        end else begin
          mul_start = 1'b1;
          mul_x = acc_q;
          mul_y = acc_q;
        end
      end
      ST_SQR: if (mul_ctl.done) begin
        acc_d = mul_r;
        r_d   = r_q + 1'b1;
      end
      ST_SQR_EVAL: begin
        if (acc_q == nm1) begin
          bi_d = bi_q + 1'b1;
          e_d  = d_q;
        end else if (r_q >= s_q) begin
          res_d = 1'b0;
        end else begin
          mul_start = 1'b1;
          mul_x = acc_q;
          mul_y = acc_q;
        end
      end
      ST_DONE: ov_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) n_q <= candidate_i;
    d_q <= d_d; e_q <= e_d; acc_q <= acc_d; b_q <= b_d;
    s_q <= s_d; r_q <= r_d; bi_q <= bi_d; res_q <= res_d;
  end

  assign out_valid_o  = ov_q;
  assign prime_flag_o = res_q;

endmodule
`default_nettype wire

@@ hdl/mrp_checker.sv @@
`default_nettype none
module mrp_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic prime_flag_o
);

  // no new item while a result waits
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("item accepted with result pending");

  // an accepted item blocks the input next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("not busy after accept");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(prime_flag_o)))
    else $error("result changed under stall");

endmodule

bind miller_rabin_primality_64_top mrp_checker u_mrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .prime_flag_o(prime_flag_o)
);
`default_nettype wire

@@ tb/miller_rabin_primality_64_top_tb.sv @@
`timescale 1ns / 1ps
module miller_rabin_primality_64_top_tb;
  import mrp_pkg::*;

  localparam int unsigned NBITS = 63;
  localparam int unsigned WATCH_LIMIT = 400000;
  localparam int unsigned HOLD_LEN = 300;
  localparam int unsigned RAND_ITEMS = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [NBITS-1:0] candidate_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic prime_flag_o;

  logic [NBITS-1:0] cand_pending[$];
  bit flag_expected[$];
  int unsigned in_count = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_cnt = 0;
  bit hold_done = 1'b0;
  bit pause_done = 1'b0;
  bit in_fire = 1'b0;

  miller_rabin_primality_64_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .candidate_i(candidate_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .prime_flag_o(prime_flag_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [63:0] mod_mul(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] m);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return 64'(p % {64'd0, m});
  endfunction

  function automatic bit prime_of(input logic [NBITS-1:0] cand);
    logic [63:0] bases [12];
    logic [63:0] n, nm1, d, x, b, e;
    int s;
    bit wit;
    bases = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd17, 64'd19, 64'd23,
              64'd29, 64'd31, 64'd37};
    n = {1'b0, cand};
    if (n < 2) return 1'b0;
    if (n == 2 || n == 3) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    nm1 = n - 1;
    d = nm1;
    s = 0;
    while (d[0] == 1'b0) begin
      d = d >> 1;
      s++;
    end
    for (int i = 0; i < 12; i++) begin
      if (bases[i] >= n) break;
      x = 64'd1;
      b = bases[i] % n;
      e = d;
      while (e != 0) begin
        if (e[0]) x = mod_mul(x, b, n);
        b = mod_mul(b, b, n);
        e = e >> 1;
      end
      if (x == 1 || x == nm1) continue;
      wit = 1'b1;
      for (int r = 1; r < s; r++) begin
        x = mod_mul(x, x, n);
        if (x == nm1) begin
          wit = 1'b0;
          break;
        end
      end
      if (wit) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned send_idle_pct();
    if (in_count < 40) return 22;
    if (in_count < 80) return 54;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (in_count < 40) return 54;
    if (in_count < 80) return 22;
    return 0;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_fire) begin
      in_valid_i <= 1'b1;
    end else if (in_count >= 50 && !pause_done) begin
      in_valid_i <= 1'b0;
      if (flag_expected.size() == 0) pause_done <= 1'b1;
    end else if (cand_pending.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
      candidate_i <= cand_pending.pop_front();
      in_valid_i <= 1'b1;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && in_count >= 30 && out_valid_o) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct());
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    bit exp_flag;
    in_fire <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        flag_expected.push_back(prime_of(candidate_i));
        in_count <= in_count + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (flag_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: prime_flag %0d", prime_flag_o);
        end else begin
          exp_flag = flag_expected.pop_front();
          if (prime_flag_o !== exp_flag) begin
            mismatches++;
            if (mismatches <= 10)
              $display("prime_flag mismatch: expected %0d actual %0d", exp_flag, prime_flag_o);
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("miller_rabin_primality_64_top_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [NBITS-1:0] rand_cand();
    logic [63:0] v;
    int unsigned pick;
    pick = $urandom_range(99);
    v = {$urandom, $urandom};
    if (pick < 60) return NBITS'($urandom_range(65535, 5) | 1);
    if (pick < 75) return v[NBITS-1:0];
    if (pick < 85) return NBITS'($urandom_range(200));
    if (pick < 95) return NBITS'({32'd0, $urandom} | 1);
    return NBITS'(v[NBITS-1:0] | 1);
  endfunction

  initial begin
    logic [NBITS-1:0] directed [$];
    directed = '{63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd5, 63'd9, 63'd37, 63'd39, 63'd41,
                 63'd561, 63'd2047, 63'd1373653, 63'd3215031751, 63'd998244353,
                 63'd4294967297, 63'd3825123056546413051, 63'h7FFFFFFFFFFFFFFF,
                 63'd9223372036854775783, 63'h7FFFFFFFFFFFFFFE, 63'h5555555555555555,
                 63'h2AAAAAAAAAAAAAAA};
    foreach (directed[i]) cand_pending.push_back(directed[i]);
    for (int i = 0; i < RAND_ITEMS; i++) cand_pending.push_back(rand_cand());
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (cand_pending.size() != 0 || in_valid_i || flag_expected.size() != 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && flag_expected.size() == 0) begin
      $display("miller_rabin_primality_64_top_tb: PASS");
    end else begin
      $display("miller_rabin_primality_64_top_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mrp_pkg.sv
hdl/mrp_mulmod.sv
hdl/miller_rabin_primality_64_top.sv
hdl/mrp_checker.sv
tb/miller_rabin_primality_64_top_tb.sv
